// ===== hw/rtl/poc_pkg.sv =====
package poc_pkg;

	// Number of patterns in the decode list, and the width of a class code.
	localparam int PATTERN_COUNT = 82;
	localparam int OPCODE_W = 16;
	localparam int CODE_W = 7;

	// Class code given when no pattern matches.
	localparam logic [CODE_W-1:0] CLASS_UNKNOWN = '0;

	// Highest class code in use.
	localparam logic [CODE_W-1:0] CLASS_LAST = CODE_W'(PATTERN_COUNT);

	// Result of one classification.
	typedef struct packed {
		logic [CODE_W-1:0] class_code;
		logic              is_known;
	} poc_result_t;

	// Pattern masks in priority order. Entry k belongs to class code k+1.
	localparam logic [OPCODE_W-1:0] PAT_MASK [PATTERN_COUNT] = '{
		16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
		16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
		16'hfff8, 16'hfff8, 16'hfff8,
		16'hfff0, 16'hfff0,
		16'hffc0, 16'hffc0, 16'hffc0, 16'hffc0, 16'hffc0, 16'hffc0, 16'hffc0, 16'hffc0,
		16'hffc0, 16'hffc0, 16'hffc0, 16'hfe38,
		16'hf0f8, 16'hf1f0, 16'hf1f0, 16'hff80, 16'hff80, 16'hf1c0,
		16'hff00, 16'hff00, 16'hff00, 16'hff00, 16'hff00, 16'hff00, 16'hff00, 16'hff00,
		16'hff00, 16'hff00, 16'hff00, 16'hf0c0, 16'hf130, 16'hf130, 16'hf0c0, 16'hf130,
		16'hf0c0, 16'hf138,
		16'hf1c0, 16'hf1c0, 16'hf1c0, 16'hf1c0, 16'hf1c0, 16'hf1c0, 16'hf1c0, 16'hf1c0,
		16'hf038,
		16'hf018, 16'hf018, 16'hf0c0, 16'hf140, 16'hf018, 16'hf018,
		16'hf100, 16'hf100, 16'hf100, 16'hf000, 16'hf100, 16'hc1c0,
		16'hf000, 16'hf000, 16'hf000, 16'hf000, 16'hf000,
		16'hc000
	};

	// Pattern compare values, in the same order as the masks.
	localparam logic [OPCODE_W-1:0] PAT_VALUE [PATTERN_COUNT] = '{
		16'h023c, 16'h027c, 16'h0a3c, 16'h0a7c, 16'h4afc, 16'h4e71, 16'h003c, 16'h007c,
		16'h4e70, 16'h4e73, 16'h4e77, 16'h4e75, 16'h4e72, 16'h4e76,
		16'h4e50, 16'h4840, 16'h4e58,
		16'h4e40, 16'h4e60,
		16'h0800, 16'h0840, 16'h0880, 16'h08c0, 16'h44c0, 16'h40c0, 16'h46c0, 16'h4840,
		16'h4ac0, 16'h4ec0, 16'h4e80, 16'h4800,
		16'h50c8, 16'hc100, 16'h8100, 16'h4880, 16'h4c80, 16'h01c0,
		16'h4200, 16'h0c00, 16'h0a00, 16'h0600, 16'h0200, 16'h0000, 16'h4400, 16'h4000,
		16'h4600, 16'h0400, 16'h4a00, 16'hd0c0, 16'hd100, 16'hc100, 16'h90c0, 16'h9100,
		16'hb0c0, 16'hb108,
		16'h0140, 16'h0180, 16'h0100, 16'h81c0, 16'h80c0, 16'hc1c0, 16'hc0c0, 16'h41c0,
		16'h0008,
		16'he018, 16'he010, 16'h50c0, 16'h4100, 16'he008, 16'he000,
		16'h5000, 16'hb100, 16'h7000, 16'h9000, 16'h5100, 16'h0040,
		16'hd000, 16'hc000, 16'h6000, 16'hb000, 16'h8000,
		16'h0000
	};

endpackage

// ===== hw/rtl/priority_opcode_class_decoder.sv =====
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   opcode_word[15:0]
// output    out        out_valid/out_stall class_code[6:0], is_known
//
// Each transfer passes through one input register and one result register,
// with the pattern match between them.
// One opcode word is accepted per cycle while the output side does not stall.
// Reset clears both valid flags; payload registers are not reset.
// An output stall holds the result register, and the input register fills
// behind it before in_stall rises.
module priority_opcode_class_decoder (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [poc_pkg::OPCODE_W-1:0]           opcode_word,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [poc_pkg::CODE_W-1:0]             class_code,
	output logic                                   is_known
);

	logic                           valid_s1;
	logic [poc_pkg::OPCODE_W-1:0]   opcode_s1;
	logic                           valid_s2;
	poc_pkg::poc_result_t           result_s2;
	poc_pkg::poc_result_t           match_result;
	logic                           adv_s1;
	logic                           adv_s2;

	// A stage moves when it is empty or the stage after it moves.
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			opcode_s1 <= opcode_word;
		end
	end

	// Pattern match on the registered opcode word.
	poc_match u_match (
		.opcode (opcode_s1),
		.result (match_result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= match_result;
		end
	end

	assign out_valid  = valid_s2;
	assign class_code = result_s2.class_code;
	assign is_known   = result_s2.is_known;

	// The known flag agrees with the class code on every delivered result.
	a_known_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_known == (class_code != poc_pkg::CLASS_UNKNOWN)))
		else $error("is_known disagrees with class_code");

	// No delivered class code lies beyond the last pattern.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (class_code <= poc_pkg::CLASS_LAST))
		else $error("class_code out of range");

	// The input side stalls only when both registers are full.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled with a free register");

	// A result that was stalled is still there in the next cycle.
	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_stall) |=> (valid_s2 && $stable(result_s2)))
		else $error("stalled result lost");

endmodule

// ===== hw/rtl/poc_match.sv =====
module poc_match (
	input  logic [poc_pkg::OPCODE_W-1:0] opcode,
	output poc_pkg::poc_result_t         result
);

	// Match every pattern at once; the earliest match in list order wins.
	// Scanning from the back lets each earlier match override a later one.
	always_comb begin
		result.class_code = poc_pkg::CLASS_UNKNOWN;
		for (int k = poc_pkg::PATTERN_COUNT - 1; k >= 0; k--) begin
			if ((opcode & poc_pkg::PAT_MASK[k]) == poc_pkg::PAT_VALUE[k]) begin
				result.class_code = poc_pkg::CODE_W'(k + 1);
			end
		end
		result.is_known = (result.class_code != poc_pkg::CLASS_UNKNOWN);
	end

endmodule
